@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers for the demand tracker; empty with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// explicit clock and active-low reset
`define WDCS_ASSERT_CLK(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);
// default clock and reset of this project
`define WDCS_ASSERT(lbl, prop, msg) \
	`WDCS_ASSERT_CLK(lbl, clk, arst_n, prop, msg)
`else
`define WDCS_ASSERT_CLK(lbl, ck, rst_n, prop, msg)
`define WDCS_ASSERT(lbl, prop, msg)
`endif

`endif

@@ design/wdcs_pkg.sv @@
// ----------------------------------------------------------------------------
// wdcs_pkg
// Shared widths, register indexes, FSM state type and control structs.
// ----------------------------------------------------------------------------
package wdcs_pkg;

	localparam int unsigned HIST_DEPTH = 8;
	localparam int unsigned HIST_IDX_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int unsigned HIST_N_W   = $clog2(HIST_DEPTH + 1);

	localparam int unsigned LOAD_W     = 31;
	localparam int unsigned SUM_W      = 39;
	localparam int unsigned TICK_W     = 8;
	localparam int unsigned HSIZE_W    = 4;
	localparam int unsigned POLICY_W   = 2;
	localparam int unsigned TOTAL_W    = LOAD_W + HIST_N_W;
	localparam int unsigned DIV_CNT_W  = $clog2(SUM_W + 1);

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 31;

	localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_UP_THR    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DOWN_THR  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HIST_SIZE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BOOST     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = 3'd5;

	// window policies
	localparam logic [POLICY_W-1:0] POL_RECENT  = 2'd0;
	localparam logic [POLICY_W-1:0] POL_MAX     = 2'd1;
	localparam logic [POLICY_W-1:0] POL_AVG     = 2'd2;
	localparam logic [POLICY_W-1:0] POL_AVG_REC = 2'd3;

	localparam logic [HSIZE_W-1:0]  HSIZE_RST     = 4'd5;
	localparam logic [POLICY_W-1:0] POLICY_RST    = POL_AVG_REC;
	localparam logic [TICK_W-1:0]   TICK_RATE_RST = 8'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_AVG,
		ST_SUM,
		ST_DIV_HIST,
		ST_EMIT
	} wdcs_state_t;

	typedef struct packed {
		logic take;
		logic div_avg_start;
		logic push;
		logic sum_step;
		logic div_hist_start;
		logic decide;
		logic emit;
	} wdcs_cmd_t;

	typedef struct packed {
		logic close;
		logic div_busy;
		logic div_done;
		logic sum_last;
		logic out_free;
	} wdcs_sts_t;

endpackage

@@ design/windowed_demand_cluster_select_top.sv @@
// ----------------------------------------------------------------------------
// windowed_demand_cluster_select_top
// Windowed load demand tracker with big/little cluster selection.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, load_sample) takes one load sample per
//   scheduler tick. Output channel (out_valid/out_ready) returns exactly one
//   result item per input item: window_done, avg_load, demand, big_active.
//   Config port (cfg_we, cfg_index, cfg_wdata) writes one register per cycle,
//   no wait state; write it only while the block is idle.
// Sequence:
//   A tick that does not close a window goes from accept to the result
//   register with no division. A tick that closes a window runs two
//   bit-serial 39-bit divisions on the one shared divider (window average of
//   the sum, then history average) with a sweep over the history entries in
//   use between them. One item at a time: the next item is taken only after
//   the result of the previous one has been written.
// Reset:
//   arst_n low clears the accumulator, the history window, demand and the
//   cluster choice (little), and loads the register defaults.
// Stall:
//   A finished result sits in the output register; the block keeps taking
//   items and working, and only holds before writing the next result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module windowed_demand_cluster_select_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// config write port
	input  logic                            cfg_we,
	input  logic [wdcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wdcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// tick samples
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [wdcs_pkg::LOAD_W-1:0]     load_sample,
	// results
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            window_done,
	output logic [wdcs_pkg::LOAD_W-1:0]     avg_load,
	output logic [wdcs_pkg::LOAD_W-1:0]     demand,
	output logic                            big_active
);
	import wdcs_pkg::*;

	wdcs_cmd_t cmd;
	wdcs_sts_t sts;

	// sequencer: one item at a time
	wdcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath incl. divider and result register
	wdcs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.load_sample (load_sample),
		.out_ready   (out_ready),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.window_done (window_done),
		.avg_load    (avg_load),
		.demand      (demand),
		.big_active  (big_active)
	);

	// a result for a tick that closed no window carries no average
	`WDCS_ASSERT(a_open_avg_zero, out_valid && !window_done |-> avg_load == '0, "avg on open window")
	// the shared divider is never restarted mid-division
	`WDCS_ASSERT(a_div_start_idle, (cmd.div_avg_start || cmd.div_hist_start) |-> !sts.div_busy, "div restart")
	// a new tick only comes in with the divider quiet
	`WDCS_ASSERT(a_take_div_idle, in_valid && in_ready |-> !sts.div_busy && !sts.div_done, "take in div")
	// completion only follows a running division
	`WDCS_ASSERT(a_done_after_busy, sts.div_done |-> $past(sts.div_busy), "div done while idle")

endmodule

@@ design/wdcs_div.sv @@
// ----------------------------------------------------------------------------
// wdcs_div
// Restoring divider, one quotient bit per cycle, shared by both averages.
// ----------------------------------------------------------------------------
module wdcs_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [wdcs_pkg::SUM_W-1:0]  dividend,
	input  logic [wdcs_pkg::TICK_W-1:0] divisor,
	output logic                        busy,
	output logic                        done,
	output logic [wdcs_pkg::SUM_W-1:0]  quotient
);
	import wdcs_pkg::*;

	logic [SUM_W-1:0]     quo_q;
	logic [TICK_W-1:0]    rem_q;
	logic [TICK_W-1:0]    dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [TICK_W:0]      trial;
	logic [TICK_W:0]      diff;
	logic                 fits;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= fits ? diff[TICK_W-1:0] : trial[TICK_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ design/wdcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// wdcs_ctrl
// Sequencer: tick accept, window average, history sweep, demand, result.
// ----------------------------------------------------------------------------
module wdcs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  wdcs_pkg::wdcs_sts_t sts,
	output wdcs_pkg::wdcs_cmd_t cmd
);
	import wdcs_pkg::*;

	wdcs_state_t state_q;
	wdcs_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = sts.close ? ST_DIV_AVG : ST_EMIT;
				end
			end
			ST_DIV_AVG: begin
				if (sts.div_done) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				if (sts.sum_last) begin
					state_d = ST_DIV_HIST;
				end
			end
			ST_DIV_HIST: begin
				if (sts.div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready          = 1'b1;
				cmd.take          = in_valid;
				cmd.div_avg_start = in_valid & sts.close;
			end
			ST_DIV_AVG: begin
				cmd.push = sts.div_done;
			end
			ST_SUM: begin
				cmd.sum_step       = 1'b1;
				cmd.div_hist_start = sts.sum_last;
			end
			ST_DIV_HIST: begin
				cmd.decide = sts.div_done;
			end
			ST_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ design/wdcs_dp.sv @@
// ----------------------------------------------------------------------------
// wdcs_dp
// Datapath: config registers, tick accumulator, history window, demand
// selection with hysteresis, shared divider and the result register.
// ----------------------------------------------------------------------------
module wdcs_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [wdcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wdcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic [wdcs_pkg::LOAD_W-1:0]     load_sample,
	input  logic                            out_ready,
	input  wdcs_pkg::wdcs_cmd_t             cmd,
	output wdcs_pkg::wdcs_sts_t             sts,
	output logic                            out_valid,
	output logic                            window_done,
	output logic [wdcs_pkg::LOAD_W-1:0]     avg_load,
	output logic [wdcs_pkg::LOAD_W-1:0]     demand,
	output logic                            big_active
);
	import wdcs_pkg::*;

	// configuration
	logic [LOAD_W-1:0]   up_thr_q;
	logic [LOAD_W-1:0]   down_thr_q;
	logic [HSIZE_W-1:0]  hsize_q;
	logic [POLICY_W-1:0] policy_q;
	logic                boost_q;
	logic [TICK_W-1:0]   tick_rate_q;

	// tick accumulation
	logic [TICK_W-1:0] tick_q;
	logic [SUM_W-1:0]  sum_q;
	logic              close_q;
	logic [TICK_W-1:0] rate;
	logic [TICK_W-1:0] tick_next;
	logic [SUM_W-1:0]  sum_next;

	// window and demand
	logic [LOAD_W-1:0]     hist_q [HIST_DEPTH];
	logic [HIST_N_W-1:0]   hist_n;
	logic [HIST_IDX_W-1:0] idx_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [TOTAL_W-1:0]    total_next;
	logic [LOAD_W-1:0]     peak_q;
	logic [LOAD_W-1:0]     peak_next;
	logic [LOAD_W-1:0]     hist_rd;
	logic [LOAD_W-1:0]     avg_q;
	logic [LOAD_W-1:0]     avg_sat;
	logic [LOAD_W-1:0]     hist_avg;
	logic [LOAD_W-1:0]     dem;
	logic [LOAD_W-1:0]     demand_q;
	logic                  big_q;

	// divider
	logic [SUM_W-1:0]  div_dividend;
	logic [TICK_W-1:0] div_divisor;
	logic              div_busy;
	logic              div_done;
	logic [SUM_W-1:0]  div_quo;

	// result register
	logic              out_valid_q;
	logic              res_done_q;
	logic [LOAD_W-1:0] res_avg_q;
	logic [LOAD_W-1:0] res_demand_q;
	logic              res_big_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_thr_q    <= '0;
			down_thr_q  <= '0;
			hsize_q     <= HSIZE_RST;
			policy_q    <= POLICY_RST;
			boost_q     <= 1'b0;
			tick_rate_q <= TICK_RATE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_UP_THR:    up_thr_q    <= cfg_wdata[LOAD_W-1:0];
				CFG_DOWN_THR:  down_thr_q  <= cfg_wdata[LOAD_W-1:0];
				CFG_HIST_SIZE: hsize_q     <= cfg_wdata[HSIZE_W-1:0];
				CFG_POLICY:    policy_q    <= cfg_wdata[POLICY_W-1:0];
				CFG_BOOST:     boost_q     <= cfg_wdata[0];
				CFG_TICK_RATE: tick_rate_q <= cfg_wdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// zero tick rate runs as one
	assign rate      = (tick_rate_q == '0) ? TICK_W'(1) : tick_rate_q;
	assign tick_next = tick_q + 1'b1;
	assign sum_next  = sum_q + SUM_W'(load_sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			sum_q   <= '0;
			close_q <= 1'b0;
		end else if (cmd.take) begin
			close_q <= sts.close;
			if (sts.close) begin
				tick_q <= '0;
				sum_q  <= '0;
			end else begin
				tick_q <= tick_next;
				sum_q  <= sum_next;
			end
		end
	end

	// size in use, clamped to 1..HIST_DEPTH
	always_comb begin
		if (hsize_q == '0) begin
			hist_n = HIST_N_W'(1);
		end else if (32'(hsize_q) > HIST_DEPTH) begin
			hist_n = HIST_N_W'(HIST_DEPTH);
		end else begin
			hist_n = HIST_N_W'(hsize_q);
		end
	end

	assign avg_sat = (|div_quo[SUM_W-1:LOAD_W]) ? LOAD_MAX : div_quo[LOAD_W-1:0];

	// entries beyond the size in use are left alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
		end else if (cmd.push) begin
			hist_q[0] <= avg_sat;
			for (int i = 1; i < HIST_DEPTH; i++) begin
				if (HIST_N_W'(i) < hist_n) begin
					hist_q[i] <= hist_q[i-1];
				end
			end
		end
	end

	assign hist_rd    = hist_q[idx_q];
	assign total_next = total_q + TOTAL_W'(hist_rd);
	assign peak_next  = (hist_rd > peak_q) ? hist_rd : peak_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			avg_q   <= avg_sat;
			idx_q   <= '0;
			total_q <= '0;
			peak_q  <= '0;
		end else if (cmd.sum_step) begin
			idx_q   <= idx_q + 1'b1;
			total_q <= total_next;
			peak_q  <= peak_next;
		end
	end

	assign div_dividend = cmd.div_avg_start ? sum_next : SUM_W'(total_next);
	assign div_divisor  = cmd.div_avg_start ? rate : TICK_W'(hist_n);

	wdcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_avg_start | cmd.div_hist_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign hist_avg = div_quo[LOAD_W-1:0];

	always_comb begin
		case (policy_q)
			POL_RECENT:  dem = avg_q;
			POL_MAX:     dem = peak_q;
			POL_AVG:     dem = hist_avg;
			POL_AVG_REC: dem = (hist_avg > avg_q) ? hist_avg : avg_q;
			default:     dem = avg_q;
		endcase
	end

	// hysteresis: between the thresholds the cluster holds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			demand_q <= '0;
			big_q    <= 1'b0;
		end else if (cmd.decide) begin
			demand_q <= dem;
			if (boost_q || (dem > up_thr_q)) begin
				big_q <= 1'b1;
			end else if (dem < down_thr_q) begin
				big_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_done_q   <= close_q;
			res_avg_q    <= close_q ? avg_q : '0;
			res_demand_q <= demand_q;
			res_big_q    <= big_q;
		end
	end

	assign sts.close    = tick_next >= rate;
	assign sts.div_busy = div_busy;
	assign sts.div_done = div_done;
	assign sts.sum_last = idx_q == HIST_IDX_W'(hist_n - 1'b1);
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign window_done = res_done_q;
	assign avg_load    = res_avg_q;
	assign demand      = res_demand_q;
	assign big_active  = res_big_q;

endmodule

@@ verif/wdcs_demand_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wdcs_demand_checker
// Watches the config port and both item channels of the demand tracker and
// keeps its own copy of the tick accumulator, history window, demand and
// cluster choice. It predicts the result item of every accepted tick and
// compares each returned result item with the oldest prediction.
// ----------------------------------------------------------------------------
module wdcs_demand_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [wdcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wdcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [wdcs_pkg::LOAD_W-1:0]     load_sample,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic                            window_done,
	input  logic [wdcs_pkg::LOAD_W-1:0]     avg_load,
	input  logic [wdcs_pkg::LOAD_W-1:0]     demand,
	input  logic                            big_active,
	output int                              errors,
	output int                              outstanding,
	output int                              windows
);
	import wdcs_pkg::*;

	typedef struct packed {
		logic              done;
		logic [LOAD_W-1:0] avg;
		logic [LOAD_W-1:0] dem;
		logic              big;
	} tick_result_t;

	// shadow registers
	logic [LOAD_W-1:0]   up_thr;
	logic [LOAD_W-1:0]   down_thr;
	logic [HSIZE_W-1:0]  hist_size;
	logic [POLICY_W-1:0] policy;
	logic                boost;
	logic [TICK_W-1:0]   tick_rate;

	// shadow state
	logic [TICK_W-1:0]   tick_cnt;
	logic [SUM_W-1:0]    load_acc;
	logic [LOAD_W-1:0]   hist [HIST_DEPTH];
	logic [LOAD_W-1:0]   demand_q;
	logic                big_q;

	tick_result_t awaited_results [$];
	int fail_cnt;
	int close_cnt;

	function automatic tick_result_t next_tick_result(input logic [LOAD_W-1:0] sample);
		tick_result_t      r;
		logic [TICK_W-1:0] rate;
		logic [SUM_W-1:0]  q;
		logic [LOAD_W-1:0] win_sample;
		logic [LOAD_W+3:0] total;
		logic [LOAD_W+3:0] hist_avg;
		logic [LOAD_W-1:0] peak;
		int                n;
		int                i;
		r = '0;
		rate = (tick_rate == '0) ? TICK_W'(1) : tick_rate;
		tick_cnt = tick_cnt + 1'b1;
		load_acc = load_acc + SUM_W'(sample);
		if (tick_cnt >= rate) begin
			q = load_acc / SUM_W'(rate);
			win_sample = (q > SUM_W'(LOAD_MAX)) ? LOAD_MAX : q[LOAD_W-1:0];
			tick_cnt = '0;
			load_acc = '0;
			// size in use: zero means one, anything past the depth saturates
			n = int'(hist_size);
			if (n == 0)
				n = 1;
			if (n > int'(HIST_DEPTH))
				n = int'(HIST_DEPTH);
			for (i = n - 1; i > 0; i--)
				hist[i] = hist[i-1];
			hist[0] = win_sample;
			total = '0;
			peak = '0;
			for (i = 0; i < n; i++) begin
				total = total + (LOAD_W+4)'(hist[i]);
				if (hist[i] > peak)
					peak = hist[i];
			end
			hist_avg = total / (LOAD_W+4)'(n);
			case (policy)
				POL_RECENT: demand_q = win_sample;
				POL_MAX:    demand_q = peak;
				POL_AVG:    demand_q = hist_avg[LOAD_W-1:0];
				default:    demand_q = (hist_avg[LOAD_W-1:0] > win_sample) ?
					hist_avg[LOAD_W-1:0] : win_sample;
			endcase
			// hysteresis: between the thresholds the cluster stays
			if (demand_q > up_thr)
				big_q = 1'b1;
			else if (demand_q < down_thr)
				big_q = 1'b0;
			if (boost)
				big_q = 1'b1;
			r.done = 1'b1;
			r.avg = win_sample;
		end
		r.dem = demand_q;
		r.big = big_q;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		tick_result_t got;
		tick_result_t want;
		int i;
		if (!arst_n) begin
			up_thr = '0;
			down_thr = '0;
			hist_size = HSIZE_RST;
			policy = POLICY_RST;
			boost = 1'b0;
			tick_rate = TICK_RATE_RST;
			tick_cnt = '0;
			load_acc = '0;
			for (i = 0; i < int'(HIST_DEPTH); i++)
				hist[i] = '0;
			demand_q = '0;
			big_q = 1'b0;
			awaited_results.delete();
			fail_cnt = 0;
			close_cnt = 0;
			errors <= 0;
			outstanding <= 0;
			windows <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_UP_THR:    up_thr = cfg_wdata[LOAD_W-1:0];
					CFG_DOWN_THR:  down_thr = cfg_wdata[LOAD_W-1:0];
					CFG_HIST_SIZE: hist_size = cfg_wdata[HSIZE_W-1:0];
					CFG_POLICY:    policy = cfg_wdata[POLICY_W-1:0];
					CFG_BOOST:     boost = cfg_wdata[0];
					CFG_TICK_RATE: tick_rate = cfg_wdata[TICK_W-1:0];
					default:       ;
				endcase
			end
			if (out_valid && out_ready) begin
				got.done = window_done;
				got.avg = avg_load;
				got.dem = demand;
				got.big = big_active;
				if (awaited_results.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("%0t: unexpected item done/avg/dem/big %0d %0d %0d %0d",
							$time, got.done, got.avg, got.dem, got.big);
				end else begin
					want = awaited_results.pop_front();
					if (got !== want) begin
						fail_cnt++;
						if (fail_cnt <= 10)
							$display("%0t: mismatch exp %0d %0d %0d %0d got %0d %0d %0d %0d",
								$time, want.done, want.avg, want.dem, want.big,
								got.done, got.avg, got.dem, got.big);
					end
				end
				if (window_done === 1'b1)
					close_cnt++;
			end
			if (in_valid && in_ready)
				awaited_results.push_back(next_tick_result(load_sample));
			errors <= fail_cnt;
			outstanding <= awaited_results.size();
			windows <= close_cnt;
		end
	end

endmodule

@@ verif/tb_windowed_demand_cluster_select_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_demand_cluster_select_top
// Stimulus and verdict for the windowed demand tracker. Drives load ticks and
// config writes, stalls both channels at random, and leaves all prediction
// and comparison to the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_windowed_demand_cluster_select_top;
	import wdcs_pkg::*;

	localparam int TICK_TARGET = 1550;
	// longest quiet spell of a correct run is one window close plus a full
	// sender gap and receiver stall; this is well clear of it
	localparam int IDLE_LIMIT  = 4000;
	localparam int TAIL_CYCLES = 120;
	// indexes past the register file; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [LOAD_W-1:0]     load_sample = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  window_done;
	logic [LOAD_W-1:0]     avg_load;
	logic [LOAD_W-1:0]     demand;
	logic                  big_active;

	int errors;
	int outstanding;
	int windows;
	int ticks_sent = 0;
	int phases = 0;
	int idle_cycles = 0;
	// set for some phases so that both sides run back to back
	bit no_idle = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	windowed_demand_cluster_select_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.load_sample (load_sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.window_done (window_done),
		.avg_load    (avg_load),
		.demand      (demand),
		.big_active  (big_active)
	);

	wdcs_demand_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.load_sample (load_sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.window_done (window_done),
		.avg_load    (avg_load),
		.demand      (demand),
		.big_active  (big_active),
		.errors      (errors),
		.outstanding (outstanding),
		.windows     (windows)
	);

	// per-item random wait; none while no_idle is set
	function automatic int draw_gap();
		return no_idle ? 0 : int'($urandom_range(0, 14));
	endfunction

	// load or threshold level: extremes, small values and the full range
	function automatic logic [LOAD_W-1:0] draw_level();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return LOAD_MAX;
			2:       return LOAD_W'($urandom_range(0, 1023));
			default: return LOAD_W'($urandom());
		endcase
	endfunction

	// narrow registers: half the time junk above the field, which must be dropped
	function automatic logic [CFG_DATA_W-1:0] pad_noise(input logic [CFG_DATA_W-1:0] field,
		input int w);
		logic [CFG_DATA_W-1:0] keep;
		keep = ~({CFG_DATA_W{1'b1}} << w);
		if ($urandom_range(0, 1) == 1)
			return (field & keep) | (CFG_DATA_W'($urandom()) & ~keep);
		return field & keep;
	endfunction

	// one register write per cycle; caller drops cfg_we after the last one
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	// one tick item; valid stays up across back-to-back items
	task automatic put_tick(input logic [LOAD_W-1:0] v);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		load_sample <= v;
		do @(posedge clk); while (!in_ready);
		ticks_sent++;
	endtask

	// stop sending and wait until every result item is back: block is idle
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic random_config();
		logic [TICK_W-1:0] rate;
		case ($urandom_range(0, 15))
			0:       rate = '0;
			1:       rate = 8'd255;
			2:       rate = TICK_W'($urandom_range(9, 254));
			default: rate = TICK_W'($urandom_range(1, 8));
		endcase
		if ($urandom_range(0, 3) != 0)
			write_reg(CFG_UP_THR, draw_level());
		if ($urandom_range(0, 3) != 0)
			write_reg(CFG_DOWN_THR, draw_level());
		if ($urandom_range(0, 3) != 0)
			write_reg(CFG_HIST_SIZE, pad_noise(CFG_DATA_W'($urandom_range(0, 15)), HSIZE_W));
		if ($urandom_range(0, 3) != 0)
			write_reg(CFG_POLICY, pad_noise(CFG_DATA_W'($urandom_range(0, 3)), POLICY_W));
		if ($urandom_range(0, 3) != 0)
			write_reg(CFG_BOOST, pad_noise(CFG_DATA_W'($urandom_range(0, 3) == 0), 1));
		if ($urandom_range(0, 3) != 0)
			write_reg(CFG_TICK_RATE, pad_noise(CFG_DATA_W'(rate), TICK_W));
		if ($urandom_range(0, 7) == 0)
			write_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
				CFG_DATA_W'($urandom()));
		cfg_we <= 1'b0;
	endtask

	// receiving side: random stall before each result item
	initial begin : result_sink
		int stall;
		while (!arst_n) @(posedge clk);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// watchdog: any accepted item on either channel restarts the count
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int n;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: rate 2, five entries, max of average and recent
		put_tick(LOAD_MAX);
		put_tick(LOAD_MAX);
		put_tick('0);
		put_tick('0);

		// zero tick rate acts as one; recent policy; hysteresis band 500..1000
		settle();
		write_reg(CFG_TICK_RATE, '0);
		write_reg(CFG_POLICY, CFG_DATA_W'(POL_RECENT));
		write_reg(CFG_UP_THR, 31'd1000);
		write_reg(CFG_DOWN_THR, 31'd500);
		cfg_we <= 1'b0;
		put_tick(31'd2000);	// above up: big
		put_tick(31'd700);	// in the band: stays big
		put_tick(31'd100);	// below down: little

		// zero history size acts as one; max policy
		settle();
		write_reg(CFG_HIST_SIZE, '0);
		write_reg(CFG_POLICY, CFG_DATA_W'(POL_MAX));
		cfg_we <= 1'b0;
		put_tick(31'd5);
		put_tick(31'd9);

		// size past the depth saturates; average policy over full-scale entries
		settle();
		write_reg(CFG_HIST_SIZE, 31'd15);
		write_reg(CFG_POLICY, CFG_DATA_W'(POL_AVG));
		cfg_we <= 1'b0;
		put_tick(LOAD_MAX);
		put_tick(LOAD_MAX);
		put_tick(LOAD_MAX);

		// shrink the window, then grow it: the far entries must come back as they were
		settle();
		write_reg(CFG_HIST_SIZE, 31'd2);
		cfg_we <= 1'b0;
		put_tick(31'd1);
		settle();
		write_reg(CFG_HIST_SIZE, 31'd8);
		cfg_we <= 1'b0;
		put_tick(31'd3);

		// long window under boost, then the rate drops below the ticks already
		// counted: closes at once and the average saturates
		settle();
		write_reg(CFG_TICK_RATE, 31'd200);
		write_reg(CFG_BOOST, 31'd1);
		cfg_we <= 1'b0;
		repeat (4) put_tick(LOAD_MAX);
		settle();
		write_reg(CFG_TICK_RATE, 31'd3);
		cfg_we <= 1'b0;
		put_tick(LOAD_MAX);

		// threshold extremes: nothing is above full scale or below zero
		settle();
		write_reg(CFG_BOOST, '0);
		write_reg(CFG_UP_THR, LOAD_MAX);
		write_reg(CFG_DOWN_THR, '0);
		write_reg(CFG_POLICY, CFG_DATA_W'(POL_AVG_REC));
		write_reg(CFG_TICK_RATE, 31'd1);
		cfg_we <= 1'b0;
		put_tick('0);
		put_tick(LOAD_MAX);
		settle();
		write_reg(CFG_UP_THR, '0);
		write_reg(CFG_DOWN_THR, LOAD_MAX);
		cfg_we <= 1'b0;
		put_tick('0);
		phases = 9;

		// random phases; a long window left open carries into the next setting
		while (ticks_sent < TICK_TARGET) begin
			settle();
			random_config();
			phases++;
			no_idle = ($urandom_range(0, 4) == 0);
			n = $urandom_range(10, 80);
			repeat (n) put_tick(draw_level());
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d ticks over %0d register settings, %0d windows closed.",
			ticks_sent, phases, windows);
		if (errors == 0 && outstanding == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+design
design/wdcs_pkg.sv
design/wdcs_div.sv
design/wdcs_ctrl.sv
design/wdcs_dp.sv
design/windowed_demand_cluster_select_top.sv
verif/wdcs_demand_checker.sv
verif/tb_windowed_demand_cluster_select_top.sv
